>>> rtl/lfu_pkg.sv
// Shared types, constants and command structs for the LFU cache table.
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int RANK_W  = IDX_W;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;
    localparam int USE_W   = 32;
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    localparam logic [USE_W-1:0] USE_MAX = '1;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [USE_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [VAL_W-1:0]  hit_value;
        logic [USE_W-1:0]  hit_count;
        logic [RANK_W-1:0] hit_rank;
        logic              vic_found;
        logic [IDX_W-1:0]  vic_idx;
        logic [RANK_W-1:0] vic_rank;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } scan_res_t;

    typedef enum logic [1:0] {
        R_NONE    = 2'd0,
        R_TOUCH   = 2'd1,
        R_REPLACE = 2'd2
    } rank_op_t;

    typedef struct packed {
        rank_op_t          op;
        logic [IDX_W-1:0]  tgt_idx;
        logic [RANK_W-1:0] tgt_rank;
        logic              evict;
        logic [IDX_W-1:0]  vic_idx;
        logic [RANK_W-1:0] vic_rank;
    } rank_cmd_t;

endpackage

>>> rtl/lfu_cache_table.sv
// Top level of the LFU cache table: sequencer, configuration register and result register.
//
// Fully associative key/value cache of 16 entries with least-frequently-used
// replacement and least-recently-used tie break. A request is accepted while
// the block is idle; then a single compare unit walks the entry RAM one entry
// per cycle, reading all 16 entries through the registered read port, and an
// update step writes the RAM and the recency ranks and loads the result
// register. in_ready is high only while the block is idle; a result waits in
// an output register, the update step is held while the previous result has
// not been taken, and a new request is accepted as soon as the update is done.
// The capacity register may be written at any time the block is idle; a value
// above 16 acts as 16, and zero stops puts from inserting new keys while keys
// already present still hit and can be updated.
module lfu_cache_table (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]        capacity,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic signed [lfu_pkg::KEY_W-1:0] key,
    input  logic signed [lfu_pkg::VAL_W-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             hit,
    output logic signed [lfu_pkg::VAL_W-1:0] read_value
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [lfu_pkg::CAP_W-1:0] cap_reg;
    logic                      op_reg;
    logic [lfu_pkg::KEY_W-1:0] key_reg;
    logic [lfu_pkg::VAL_W-1:0] val_reg;
    logic [lfu_pkg::CNT_W-1:0] addr_reg;
    logic [lfu_pkg::CNT_W-1:0] addr_next;
    logic                      pend_reg;
    logic                      pend_next;
    logic [lfu_pkg::IDX_W-1:0] pidx_reg;
    logic [lfu_pkg::IDX_W-1:0] pidx_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      hit_reg;
    logic                      hit_next;
    logic [lfu_pkg::VAL_W-1:0] rv_reg;
    logic [lfu_pkg::VAL_W-1:0] rv_next;

    logic                       accept;
    logic                       rd_en;
    logic                       fire;
    logic                       wr_en;
    logic [lfu_pkg::IDX_W-1:0]  wr_addr;
    lfu_pkg::entry_t            wr_entry;
    logic [lfu_pkg::ENTRY_W-1:0] rd_data;
    lfu_pkg::entry_t            rd_entry;
    lfu_pkg::scan_res_t         sres;
    lfu_pkg::rank_cmd_t         rcmd;
    logic                       ent_valid;
    logic [lfu_pkg::RANK_W-1:0] ent_rank;
    logic [lfu_pkg::CNT_W-1:0]  occ;
    logic [lfu_pkg::CMP_W-1:0]  cap_ext;
    logic [lfu_pkg::CMP_W-1:0]  cap_eff;
    logic                       full;
    logic                       is_put;
    logic [lfu_pkg::USE_W-1:0]  count_inc;
    logic [lfu_pkg::IDX_W-1:0]  slot;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign rd_en     = (state_reg == S_SCAN) && (addr_reg != lfu_pkg::CNT_W'(lfu_pkg::ENTRIES));
    assign fire      = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);
    assign is_put    = (op_reg == lfu_pkg::OP_PUT);
    assign rd_entry  = lfu_pkg::entry_t'(rd_data);

    assign cap_ext = lfu_pkg::CMP_W'(cap_reg);
    assign cap_eff = (cap_ext > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) ?
                     lfu_pkg::CMP_W'(lfu_pkg::ENTRIES) : cap_ext;
    assign full    = (lfu_pkg::CMP_W'(occ) >= cap_eff);

    assign count_inc = (sres.hit_count == lfu_pkg::USE_MAX) ?
                       lfu_pkg::USE_MAX : sres.hit_count + lfu_pkg::USE_W'(1);

    // After an eviction the new entry goes to the lowest free index, which
    // may be the victim's own slot.
    assign slot = (full && !(sres.free_found && (sres.free_idx < sres.vic_idx))) ?
                  sres.vic_idx : sres.free_idx;

    lfu_ram #(
        .WIDTH(lfu_pkg::ENTRY_W),
        .DEPTH(lfu_pkg::ENTRIES)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_entry),
        .rd_en  (rd_en),
        .rd_addr(addr_reg[lfu_pkg::IDX_W-1:0]),
        .rd_data(rd_data)
    );

    lfu_rank u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (rcmd),
        .rd_idx   (pidx_reg),
        .rd_valid (ent_valid),
        .rd_rank  (ent_rank),
        .occupancy(occ)
    );

    lfu_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept),
        .sample   (pend_reg),
        .idx      (pidx_reg),
        .ent_valid(ent_valid),
        .ent_rank (ent_rank),
        .ent      (rd_entry),
        .key      (key_reg),
        .res      (sres)
    );

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    pend_next = 1'b1;
                    pidx_next = addr_reg[lfu_pkg::IDX_W-1:0];
                    addr_next = addr_reg + lfu_pkg::CNT_W'(1);
                end
                else
                begin
                    // The last entry is sampled at this edge.
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en          = 1'b0;
        wr_addr        = sres.hit_idx;
        wr_entry.key   = key_reg;
        wr_entry.value = val_reg;
        wr_entry.count = count_inc;
        rcmd.op        = lfu_pkg::R_NONE;
        rcmd.tgt_idx   = sres.hit_idx;
        rcmd.tgt_rank  = sres.hit_rank;
        rcmd.evict     = 1'b0;
        rcmd.vic_idx   = sres.vic_idx;
        rcmd.vic_rank  = sres.vic_rank;
        out_valid_next = out_valid_reg && !out_ready;
        hit_next       = hit_reg;
        rv_next        = rv_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            hit_next       = sres.hit;
            rv_next        = '0;
            if (sres.hit)
            begin
                wr_en   = 1'b1;
                rcmd.op = lfu_pkg::R_TOUCH;
                if (!is_put)
                begin
                    wr_entry.value = sres.hit_value;
                    rv_next        = sres.hit_value;
                end
            end
            else if (is_put && (cap_eff != '0))
            begin
                wr_en          = 1'b1;
                wr_addr        = slot;
                wr_entry.count = lfu_pkg::USE_W'(1);
                rcmd.op        = lfu_pkg::R_REPLACE;
                rcmd.tgt_idx   = slot;
                rcmd.evict     = full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= lfu_pkg::CAP_RESET;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        hit_reg  <= hit_next;
        rv_reg   <= rv_next;
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            val_reg <= value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign read_value = rv_reg;

endmodule

>>> rtl/lfu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/lfu_scan.sv
// Shared compare unit: one entry per cycle for key match, victim and free slot.
module lfu_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       sample,
    input  logic [lfu_pkg::IDX_W-1:0]  idx,
    input  logic                       ent_valid,
    input  logic [lfu_pkg::RANK_W-1:0] ent_rank,
    input  lfu_pkg::entry_t            ent,
    input  logic [lfu_pkg::KEY_W-1:0]  key,
    output lfu_pkg::scan_res_t         res
);

    lfu_pkg::scan_res_t res_reg;
    lfu_pkg::scan_res_t res_next;
    logic [lfu_pkg::USE_W-1:0] vic_count_reg;
    logic [lfu_pkg::USE_W-1:0] vic_count_next;
    logic key_eq;
    logic better;

    assign key_eq = (ent.key == key);

    // Lower count wins; on equal counts the older entry (higher rank) wins.
    assign better = !res_reg.vic_found || (ent.count < vic_count_reg) ||
                    ((ent.count == vic_count_reg) && (ent_rank > res_reg.vic_rank));

    always_comb
    begin
        res_next       = res_reg;
        vic_count_next = vic_count_reg;
        if (clear)
        begin
            res_next.hit        = 1'b0;
            res_next.vic_found  = 1'b0;
            res_next.free_found = 1'b0;
        end
        else if (sample)
        begin
            if (ent_valid)
            begin
                if (key_eq && !res_reg.hit)
                begin
                    res_next.hit       = 1'b1;
                    res_next.hit_idx   = idx;
                    res_next.hit_value = ent.value;
                    res_next.hit_count = ent.count;
                    res_next.hit_rank  = ent_rank;
                end
                if (better)
                begin
                    res_next.vic_found = 1'b1;
                    res_next.vic_idx   = idx;
                    res_next.vic_rank  = ent_rank;
                    vic_count_next     = ent.count;
                end
            end
            else if (!res_reg.free_found)
            begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg       <= '0;
            vic_count_reg <= '0;
        end
        else
        begin
            res_reg       <= res_next;
            vic_count_reg <= vic_count_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/lfu_rank.sv
// Valid bits, recency ranks and occupancy count, updated by each command.
module lfu_rank (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lfu_pkg::rank_cmd_t         cmd,
    input  logic [lfu_pkg::IDX_W-1:0]  rd_idx,
    output logic                       rd_valid,
    output logic [lfu_pkg::RANK_W-1:0] rd_rank,
    output logic [lfu_pkg::CNT_W-1:0]  occupancy
);

    logic [lfu_pkg::ENTRIES-1:0] valid_reg;
    logic [lfu_pkg::ENTRIES-1:0] valid_next;
    logic [lfu_pkg::RANK_W-1:0]  rank_reg  [lfu_pkg::ENTRIES];
    logic [lfu_pkg::RANK_W-1:0]  rank_next [lfu_pkg::ENTRIES];
    logic [lfu_pkg::CNT_W-1:0]   occ_reg;
    logic [lfu_pkg::CNT_W-1:0]   occ_next;

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        unique case (cmd.op)
            lfu_pkg::R_NONE:
            begin
            end
            lfu_pkg::R_TOUCH:
            begin
                for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                begin
                    if (lfu_pkg::IDX_W'(i) == cmd.tgt_idx)
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < cmd.tgt_rank))
                    begin
                        rank_next[i] = rank_reg[i] + lfu_pkg::RANK_W'(1);
                    end
                end
            end
            lfu_pkg::R_REPLACE:
            begin
                // Eviction closes the gap left by the victim, then every
                // remaining entry ages by one to make room for the new one.
                for (int i = 0; i < lfu_pkg::ENTRIES; i++)
                begin
                    if (lfu_pkg::IDX_W'(i) == cmd.tgt_idx)
                    begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (cmd.evict && (lfu_pkg::IDX_W'(i) == cmd.vic_idx))
                    begin
                        valid_next[i] = 1'b0;
                    end
                    else if (valid_reg[i])
                    begin
                        if (cmd.evict && (rank_reg[i] > cmd.vic_rank))
                        begin
                            rank_next[i] = rank_reg[i];
                        end
                        else
                        begin
                            rank_next[i] = rank_reg[i] + lfu_pkg::RANK_W'(1);
                        end
                    end
                end
                if (!cmd.evict)
                begin
                    occ_next = occ_reg + lfu_pkg::CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg <= rank_next;
    end

    assign rd_valid  = valid_reg[rd_idx];
    assign rd_rank   = rank_reg[rd_idx];
    assign occupancy = occ_reg;

endmodule
